/* rtl/core/kuct_pkg.sv */
// kuct_pkg: shared types and constants for the keyed unread counter table
// no dependencies; imported by kuct_slot_store, keyed_unread_counter_table_unit, kuct_checker and the bench
package kuct_pkg;

  // fixed field widths of the request and result words
  localparam int KEY_BITS       = 48;
  localparam int OUT_COUNT_BITS = 16;
  localparam int TOTAL_BITS     = 21;

  // parameter defaults
  localparam int SLOTS_DEF      = 24;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = '1;
  localparam logic [TOTAL_BITS-1:0]     TOTAL_MAX     = '1;

  typedef enum logic [1:0] {
    REQ_BUMP  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_GET   = 2'd2,
    REQ_TOTAL = 2'd3
  } req_type_t;

endpackage

/* rtl/core/keyed_unread_counter_table_unit.sv */
// keyed_unread_counter_table_unit: top level of the keyed unread counter table
// depends on kuct_pkg and kuct_slot_store
//
//  channel | ports                                   | direction | word
//  --------+-----------------------------------------+-----------+------------------------------
//  in      | in_valid, in_stall, in_req_type, in_key | to block  | one request (type, 48b key)
//  out     | out_valid, out_stall, out_count,        | from block| one result per request
//          | out_total, out_dropped                  |           |
//
//  requests are handled one at a time: the next accept waits until the current result is loaded,
//  as the single key comparator walks the slot memory one slot per cycle
//  reset clears the live bits and the running sum; slot memories need no clearing pass
//  in_stall is high from accept until the result word is loaded into the output register
//  a result word waiting on out_stall does not block the next request from starting,
//  but that request holds in its output step until the waiting word is taken
module keyed_unread_counter_table_unit
  import kuct_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_req_type,
  input  logic [KEY_BITS-1:0]       in_key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [OUT_COUNT_BITS-1:0] out_count,
  output logic [TOTAL_BITS-1:0]     out_total,
  output logic                      out_dropped
);

  // slot index width and exact sum width (no overflow at any parameter value)
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SUM_W = COUNT_BITS + $clog2(SLOTS + 1);
  // widths used to saturate results onto the fixed output fields
  localparam int CW    = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;
  localparam int TW    = (SUM_W > TOTAL_BITS) ? SUM_W : TOTAL_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // waiting for a request
    S_SCAN = 4'b0010,  // walking the slots through the comparator
    S_UPD  = 4'b0100,  // applying the bump and forming the result
    S_OUT  = 4'b1000   // handing the result to the output register
  } state_t;

  // control state
  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;          // read address being issued
  logic                issue_r, issue_nxt;      // still issuing slot reads
  logic                cmp_vld_r, cmp_vld_nxt;  // compare stage holds a slot
  logic [IDX_W-1:0]    cmp_idx_r;
  logic [SLOTS-1:0]    live_r, live_nxt;        // slot has a nonzero counter
  logic [SUM_W-1:0]    sum_r, sum_nxt;          // exact sum of all counters
  logic                out_valid_r, out_valid_nxt;

  // request and scan results
  req_type_t           req_r;
  logic [KEY_BITS-1:0] key_r;
  logic                mf_r, mf_nxt;            // live slot with matching key seen
  logic [IDX_W-1:0]    midx_r, midx_nxt;
  logic [COUNT_BITS-1:0] mcnt_r, mcnt_nxt;
  logic                ff_r, ff_nxt;            // free slot seen
  logic [IDX_W-1:0]    fidx_r, fidx_nxt;
  logic [COUNT_BITS-1:0] res_cnt_r, res_cnt_nxt;
  logic                drop_r, drop_nxt;

  // output register
  logic [OUT_COUNT_BITS-1:0] out_count_r;
  logic [TOTAL_BITS-1:0]     out_total_r;
  logic                      out_dropped_r;

  // slot store ports
  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  key_we, cnt_we;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] wr_cnt;

  logic                  accept;
  logic                  load_out;
  logic                  slot_live;
  logic                  slot_hit;
  logic [CW-1:0]         cnt_ext;
  logic [TW-1:0]         tot_ext;

  kuct_slot_store #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk     (clk),
    .rd_addr (idx_r),
    .rd_key  (rd_key),
    .rd_cnt  (rd_cnt),
    .key_we  (key_we),
    .cnt_we  (cnt_we),
    .wr_addr (wr_addr),
    .wr_key  (key_r),
    .wr_cnt  (wr_cnt)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  // the shared comparator: one slot per cycle, in the cycle after its read address is issued
  assign slot_live = live_r[cmp_idx_r];
  assign slot_hit  = slot_live && (rd_key == key_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    issue_nxt     = issue_r;
    cmp_vld_nxt   = 1'b0;
    live_nxt      = live_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    mf_nxt        = mf_r;
    midx_nxt      = midx_r;
    mcnt_nxt      = mcnt_r;
    ff_nxt        = ff_r;
    fidx_nxt      = fidx_r;
    res_cnt_nxt   = res_cnt_r;
    drop_nxt      = drop_r;
    key_we        = 1'b0;
    cnt_we        = 1'b0;
    wr_addr       = '0;
    wr_cnt        = '0;
    load_out      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
          issue_nxt = 1'b1;
          mf_nxt    = 1'b0;
          ff_nxt    = 1'b0;
        end
      end
      S_SCAN: begin
        if (issue_r) begin
          cmp_vld_nxt = 1'b1;
          if (idx_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (!cmp_vld_r) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        res_cnt_nxt = '0;
        drop_nxt    = 1'b0;
        state_nxt   = S_OUT;
        case (req_r)
          REQ_BUMP: begin
            if (mf_r) begin
              // saturating increment of the matching slot
              if (&mcnt_r) begin
                res_cnt_nxt = mcnt_r;
              end else begin
                cnt_we      = 1'b1;
                wr_addr     = midx_r;
                wr_cnt      = mcnt_r + 1'b1;
                res_cnt_nxt = mcnt_r + 1'b1;
                sum_nxt     = sum_r + 1'b1;
              end
            end else if (ff_r) begin
              // claim the lowest free slot
              key_we           = 1'b1;
              cnt_we           = 1'b1;
              wr_addr          = fidx_r;
              wr_cnt           = COUNT_BITS'(1);
              live_nxt[fidx_r] = 1'b1;
              res_cnt_nxt      = COUNT_BITS'(1);
              sum_nxt          = sum_r + 1'b1;
            end else begin
              drop_nxt = 1'b1;
            end
          end
          REQ_GET: begin
            if (mf_r) begin
              res_cnt_nxt = mcnt_r;
            end
          end
          REQ_CLEAR: begin
            // slots were already retired during the scan
          end
          REQ_TOTAL: begin
          end
          default: begin
          end
        endcase
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // compare stage, only active while scanning
    if (cmp_vld_r) begin
      if (slot_hit && !mf_r) begin
        mf_nxt   = 1'b1;
        midx_nxt = cmp_idx_r;
        mcnt_nxt = rd_cnt;
      end
      if (!slot_live && !ff_r) begin
        ff_nxt   = 1'b1;
        fidx_nxt = cmp_idx_r;
      end
      if (slot_hit && (req_r == REQ_CLEAR)) begin
        live_nxt[cmp_idx_r] = 1'b0;
        sum_nxt             = sum_r - SUM_W'(rd_cnt);
      end
    end
  end

  // saturate onto the fixed result fields
  assign cnt_ext = CW'(res_cnt_r);
  assign tot_ext = TW'(sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      live_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      live_r      <= live_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
    mf_r      <= mf_nxt;
    midx_r    <= midx_nxt;
    mcnt_r    <= mcnt_nxt;
    ff_r      <= ff_nxt;
    fidx_r    <= fidx_nxt;
    res_cnt_r <= res_cnt_nxt;
    drop_r    <= drop_nxt;
    if (accept) begin
      req_r <= req_type_t'(in_req_type);
      key_r <= in_key;
    end
    if (load_out) begin
      out_count_r   <= (cnt_ext > CW'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                       : cnt_ext[OUT_COUNT_BITS-1:0];
      out_total_r   <= (tot_ext > TW'(TOTAL_MAX)) ? TOTAL_MAX : tot_ext[TOTAL_BITS-1:0];
      out_dropped_r <= drop_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_count   = out_count_r;
  assign out_total   = out_total_r;
  assign out_dropped = out_dropped_r;

  // a dropped bump never reports a count
  a_drop_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_count == '0)
    else $error("dropped word carries a nonzero count");

  // every live slot holds at least one, so the sum covers the live slot count
  a_sum_covers_live: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r >= SUM_W'($countones(live_r)))
    else $error("running sum below live slot count");

  // a key is only written into a slot that is free
  a_claim_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    key_we |-> !live_r[wr_addr])
    else $error("key written into a live slot");

  // the update step always hands off to the output step
  a_upd_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |=> state_r == S_OUT)
    else $error("update step did not move to output");

  // the compare stage only runs during a scan
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> state_r == S_SCAN)
    else $error("compare stage active outside scan");

endmodule

/* rtl/core/kuct_slot_store.sv */
// kuct_slot_store: slot key and counter memories, one read and one write port each
// depends on kuct_pkg (key width)
module kuct_slot_store
  import kuct_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                  clk,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [KEY_BITS-1:0]   rd_key,
  output logic [COUNT_BITS-1:0] rd_cnt,
  input  logic                  key_we,
  input  logic                  cnt_we,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [KEY_BITS-1:0]   wr_key,
  input  logic [COUNT_BITS-1:0] wr_cnt
);

  logic [KEY_BITS-1:0]   key_mem [SLOTS];
  logic [COUNT_BITS-1:0] cnt_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
    rd_cnt <= cnt_mem[rd_addr];
  end

endmodule

/* dv/kuct_checker.sv */
// kuct_checker: watches both channels of the keyed unread counter table, checks every word
// keeps its own copy of the slot table to predict each word; depends on kuct_pkg
`timescale 1ns / 100ps

module kuct_checker
  import kuct_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [1:0]                in_req_type,
  input  logic [KEY_BITS-1:0]       in_key,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [OUT_COUNT_BITS-1:0] out_count,
  input  logic [TOTAL_BITS-1:0]     out_total,
  input  logic                      out_dropped,
  output int                        fail_count,
  output int                        pending
);

  localparam int NSLOTS = SLOTS_DEF;
  localparam int CNT_W  = COUNT_BITS_DEF;
  localparam logic [CNT_W-1:0] CNT_FULL = '1;

  typedef struct packed {
    logic [OUT_COUNT_BITS-1:0] count;
    logic [TOTAL_BITS-1:0]     total;
    logic                      dropped;
  } unread_result_t;

  logic [KEY_BITS-1:0] peer_key   [NSLOTS];
  logic [CNT_W-1:0]    unread_cnt [NSLOTS];
  unread_result_t      expected_words [$];
  int                  errors = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    errors++;
  endtask

  // updates the slot table for one request and returns the word it should produce
  task automatic apply_request(input req_type_t op, input logic [KEY_BITS-1:0] k,
                               output unread_result_t r);
    int          hit;
    int          vacant;
    int          i;
    logic [31:0] sum;
    logic [31:0] cnt32;
    hit    = -1;
    vacant = -1;
    sum    = '0;
    cnt32  = '0;
    r      = '0;
    for (i = 0; i < NSLOTS; i++) begin
      if (hit < 0 && unread_cnt[i] != '0 && peer_key[i] == k) hit = i;
      if (vacant < 0 && unread_cnt[i] == '0) vacant = i;
    end
    case (op)
      REQ_BUMP: begin
        if (hit >= 0) begin
          if (unread_cnt[hit] != CNT_FULL) unread_cnt[hit] = unread_cnt[hit] + 1'b1;
          cnt32 = 32'(unread_cnt[hit]);
        end else if (vacant >= 0) begin
          peer_key[vacant]   = k;
          unread_cnt[vacant] = CNT_W'(1);
          cnt32              = 32'd1;
        end else begin
          r.dropped = 1'b1;
        end
      end
      REQ_CLEAR: begin
        for (i = 0; i < NSLOTS; i++)
          if (unread_cnt[i] != '0 && peer_key[i] == k) unread_cnt[i] = '0;
      end
      REQ_GET: begin
        if (hit >= 0) cnt32 = 32'(unread_cnt[hit]);
      end
      default: ;
    endcase
    for (i = 0; i < NSLOTS; i++) sum = sum + 32'(unread_cnt[i]);
    r.total = (sum > 32'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
    r.count = (cnt32 > 32'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX : cnt32[OUT_COUNT_BITS-1:0];
  endtask

  always @(posedge clk) begin
    unread_result_t predicted;
    unread_result_t oldest;
    if (!rst_n) begin
      for (int i = 0; i < NSLOTS; i++) unread_cnt[i] = '0;
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(req_type_t'(in_req_type), in_key, predicted);
        expected_words.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf(
            "result word with none expected: count %0d total %0d dropped %0b",
            out_count, out_total, out_dropped));
        end else begin
          oldest = expected_words.pop_front();
          if (out_count !== oldest.count)
            report_mismatch($sformatf("count mismatch: got %0d, expected %0d",
                                      out_count, oldest.count));
          if (out_total !== oldest.total)
            report_mismatch($sformatf("total mismatch: got %0d, expected %0d",
                                      out_total, oldest.total));
          if (out_dropped !== oldest.dropped)
            report_mismatch($sformatf("dropped mismatch: got %0b, expected %0b",
                                      out_dropped, oldest.dropped));
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_words.size();
  end

endmodule

/* dv/tb_keyed_unread_counter_table_unit.sv */
// tb_keyed_unread_counter_table_unit: stimulus and verdict for the keyed unread counter table
// depends on kuct_pkg, keyed_unread_counter_table_unit and kuct_checker
`timescale 1ns / 100ps

module tb_keyed_unread_counter_table_unit;
  import kuct_pkg::*;

  localparam int NUM_ITEMS       = 850;
  localparam int POOL_SIZE       = 28;           // a few more peers than slots, so the table fills
  localparam int PRESSURE_AT     = 150;          // result word index where the long hold-off starts
  localparam int PRESSURE_CYCLES = 400;
  localparam int SETTLE_CYCLES   = SLOTS_DEF + 8;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                in_req_type;
  logic [KEY_BITS-1:0]       in_key;
  logic                      out_valid;
  logic                      out_stall;
  logic [OUT_COUNT_BITS-1:0] out_count;
  logic [TOTAL_BITS-1:0]     out_total;
  logic                      out_dropped;

  int fail_count;
  int pending;

  // per-side idling switches, flipped now and then to get stretches with no gaps
  bit tx_idle;
  bit rx_idle;
  int words_sent;
  int words_taken;

  // peer keys the well-formed traffic draws from
  logic [KEY_BITS-1:0] peer_pool [POOL_SIZE];
  // random keys bumped by noise traffic, cleared again by sweeps so slots come free
  logic [KEY_BITS-1:0] stray_keys [$];
  int                  fill_idx;

  keyed_unread_counter_table_unit dut (.*);

  kuct_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [KEY_BITS-1:0] rand_key();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // offer one request word, called and returning at a falling edge
  task automatic send_word(input req_type_t op, input logic [KEY_BITS-1:0] k);
    int gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= op;
    in_key      <= k;
    // wait for the accepting edge
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // result side: a random hold-off per word, plus one long hold-off to back up the block
  initial begin
    int hold;
    out_stall   = 1'b0;
    rx_idle     = 1'b1;
    words_taken = 0;
    @(posedge rst_n);
    forever begin
      if (words_taken % 64 == 0) rx_idle = ($urandom_range(0, 2) != 0);
      hold = rx_idle ? $urandom_range(0, 17) : 0;
      // long stretch while the sender keeps offering, so in_stall must rise
      if (words_taken == PRESSURE_AT) hold = PRESSURE_CYCLES;
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      words_taken++;
    end
  end

  initial begin
    int                  seg_mode;
    int                  seg_len;
    int                  pick;
    req_type_t           op;
    logic [KEY_BITS-1:0] k;
    in_valid    = 1'b0;
    in_req_type = REQ_TOTAL;
    in_key      = '0;
    rst_n       = 1'b0;
    tx_idle     = 1'b0;
    words_sent  = 0;
    fill_idx    = 0;
    for (int i = 0; i < POOL_SIZE; i++) peer_pool[i] = rand_key();
    // key extremes are part of the pool too
    peer_pool[0] = '0;
    peer_pool[1] = '1;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: every request type on an empty and a partly filled table, key extremes,
    // clear and get of absent keys, reuse of the lowest freed slot
    tx_idle = $urandom_range(0, 1);
    send_word(REQ_GET,   '0);
    send_word(REQ_TOTAL, '1);
    send_word(REQ_CLEAR, '0);
    send_word(REQ_BUMP,  '0);
    send_word(REQ_BUMP,  '0);
    send_word(REQ_BUMP,  '1);
    send_word(REQ_BUMP,  48'h5555_5555_5555);
    send_word(REQ_BUMP,  48'hAAAA_AAAA_AAAA);
    tx_idle = $urandom_range(0, 1);
    send_word(REQ_GET,   '1);
    send_word(REQ_GET,   48'h0000_0000_0001);   // near a live key, must miss
    send_word(REQ_CLEAR, '0);                   // frees the lowest slot
    send_word(REQ_GET,   '0);
    send_word(REQ_BUMP,  48'h8000_0000_0000);   // should land in the freed slot
    send_word(REQ_BUMP,  '1);
    send_word(REQ_TOTAL, 48'h5555_5555_5555);   // key ignored, count 0
    send_word(REQ_CLEAR, 48'h5555_5555_5555);
    send_word(REQ_CLEAR, '1);
    send_word(REQ_CLEAR, 48'hAAAA_AAAA_AAAA);
    send_word(REQ_CLEAR, 48'h8000_0000_0000);
    send_word(REQ_TOTAL, '0);                   // table empty again

    // random part, in segments of one traffic kind each
    while (words_sent < NUM_ITEMS) begin
      seg_mode = $urandom_range(0, 7);
      seg_len  = $urandom_range(8, 40);
      tx_idle  = ($urandom_range(0, 3) != 0);
      for (int j = 0; j < seg_len && words_sent < NUM_ITEMS; j++) begin
        case (seg_mode)
          // fill run: bumps walk the pool in order, so with more peers than
          // slots the table runs full and later new peers get dropped
          4, 5: begin
            op = REQ_BUMP;
            k  = peer_pool[fill_idx % POOL_SIZE];
            fill_idx++;
          end
          // noise: any type, any key
          6: begin
            op = req_type_t'($urandom_range(0, 3));
            k  = rand_key();
            if (op == REQ_BUMP) stray_keys.push_back(k);
          end
          // sweep: clear stray keys first, then pool peers
          7: begin
            op = REQ_CLEAR;
            k  = (stray_keys.size() > 0) ? stray_keys.pop_front()
                                         : peer_pool[$urandom_range(0, POOL_SIZE - 1)];
          end
          // mixed peer traffic, bump heavy
          default: begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      op = REQ_BUMP;
            else if (pick < 72) op = REQ_CLEAR;
            else if (pick < 90) op = REQ_GET;
            else                op = REQ_TOTAL;
            k = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
          end
        endcase
        send_word(op, k);
      end
    end
    in_valid <= 1'b0;

    // drain, then give a late or extra word time to show up
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
